// ===== src/ors_pkg.sv =====
// ----------------------------------------------------------------------------
// ors_pkg: shared types and helpers of the 1-Wire ROM search engine
// Request and result layouts, status codes and the byte-wise CRC-8 step.
// ----------------------------------------------------------------------------
package ors_pkg;

  localparam int ROM_BYTES_DEF = 8;
  localparam int ROM_ID_W      = 64;
  localparam int FAMILY_LIMIT  = 9;
  localparam logic [7:0] CRC_POLY = 8'h8C;

  typedef enum logic [1:0] {
    FUNC_FIRST = 2'd0,
    FUNC_NEXT  = 2'd1,
    FUNC_BIT   = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    ST_RUNNING     = 3'd0,
    ST_FOUND       = 3'd1,
    ST_NO_PRESENCE = 3'd2,
    ST_NO_RESPONSE = 3'd3,
    ST_CRC_ERROR   = 3'd4,
    ST_EXHAUSTED   = 3'd5,
    ST_STARTED     = 3'd6,
    ST_IGNORED     = 3'd7
  } status_t;

  typedef struct packed {
    logic [1:0] func;
    logic       presence;
    logic       id_bit;
    logic       cmp_bit;
  } req_t;

  typedef struct packed {
    status_t               status;
    logic                  dir_valid;
    logic                  write_dir;
    logic [ROM_ID_W-1:0]   rom_id;
    logic                  last_device;
    logic [3:0]            family_discrepancy;
  } res_t;

  // reflected crc-8, one byte folded in
  function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== src/ors_in_stage.sv =====
// ----------------------------------------------------------------------------
// ors_in_stage: input register of the ROM search engine
// Holds one request; refills in the same cycle the held one moves on.
// ----------------------------------------------------------------------------
module ors_in_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_valid,
  output logic          s_ready,
  input  ors_pkg::req_t s_req,
  input  logic          take,
  output logic          valid,
  output ors_pkg::req_t req
);

  assign s_ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_ready) begin
      valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      req <= s_req;
    end
  end

endmodule

// ===== src/ors_core.sv =====
// ----------------------------------------------------------------------------
// ors_core: search state and per-request decision logic
// Chooses the direction bit, tracks discrepancies, rom code and crc.
// ----------------------------------------------------------------------------
module ors_core #(
  parameter int ROM_BYTES = ors_pkg::ROM_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  ors_pkg::req_t req,
  output ors_pkg::res_t res
);

  localparam int RomBits = ROM_BYTES * 8;
  localparam int PosW    = $clog2(RomBits + 2);
  localparam int IdxW    = $clog2(RomBits);
  localparam int RomIdW  = ors_pkg::ROM_ID_W;

  logic [PosW-1:0]    last_disc, last_disc_next;
  logic               last_dev, last_dev_next;
  logic [3:0]         family_disc, family_disc_next;
  logic [RomBits-1:0] rom_code, rom_code_next;
  logic [PosW-1:0]    bit_pos, bit_pos_next;
  logic [PosW-1:0]    zero_fork, zero_fork_next;
  logic [7:0]         crc_acc, crc_acc_next;
  logic               pass_active, pass_active_next;

  logic [PosW-1:0]        idx_full;
  logic [IdxW-1:0]        idx;
  logic [IdxW-4:0]        byte_i;
  logic [7:0]             byte_new;
  logic                   dir;
  logic                   dvalid;
  ors_pkg::status_t       status;

  assign idx_full = bit_pos - PosW'(1);
  assign idx      = idx_full[IdxW-1:0];
  assign byte_i   = idx[IdxW-1:3];

  always_comb begin
    last_disc_next   = last_disc;
    last_dev_next    = last_dev;
    family_disc_next = family_disc;
    rom_code_next    = rom_code;
    bit_pos_next     = bit_pos;
    zero_fork_next   = zero_fork;
    crc_acc_next     = crc_acc;
    pass_active_next = pass_active;
    dir              = 1'b0;
    dvalid           = 1'b0;
    byte_new         = 8'd0;
    status           = ors_pkg::ST_IGNORED;

    unique case (req.func)
      ors_pkg::FUNC_FIRST, ors_pkg::FUNC_NEXT: begin
        if (req.func == ors_pkg::FUNC_FIRST) begin
          last_disc_next   = '0;
          last_dev_next    = 1'b0;
          family_disc_next = '0;
        end
        bit_pos_next     = PosW'(1);
        zero_fork_next   = '0;
        crc_acc_next     = '0;
        pass_active_next = 1'b0;
        if (last_dev_next) begin
          last_disc_next   = '0;
          last_dev_next    = 1'b0;
          family_disc_next = '0;
          status           = ors_pkg::ST_EXHAUSTED;
        end else if (!req.presence) begin
          last_disc_next   = '0;
          last_dev_next    = 1'b0;
          family_disc_next = '0;
          status           = ors_pkg::ST_NO_PRESENCE;
        end else begin
          pass_active_next = 1'b1;
          status           = ors_pkg::ST_STARTED;
        end
      end
      ors_pkg::FUNC_BIT: begin
        if (pass_active) begin
          if (req.id_bit && req.cmp_bit) begin
            pass_active_next = 1'b0;
            last_disc_next   = '0;
            last_dev_next    = 1'b0;
            family_disc_next = '0;
            status           = ors_pkg::ST_NO_RESPONSE;
          end else begin
            if (req.id_bit != req.cmp_bit) begin
              dir = req.id_bit;
            end else begin
              // discrepancy: follow old path, take one at the last fork, else zero
              if (bit_pos < last_disc) begin
                dir = rom_code[idx];
              end else begin
                dir = (bit_pos == last_disc);
              end
              if (!dir) begin
                zero_fork_next = bit_pos;
                if (bit_pos < PosW'(ors_pkg::FAMILY_LIMIT)) begin
                  family_disc_next = bit_pos[3:0];
                end
              end
            end
            rom_code_next[idx] = dir;
            dvalid             = 1'b1;
            bit_pos_next       = bit_pos + PosW'(1);
            status             = ors_pkg::ST_RUNNING;
            byte_new           = rom_code_next[{byte_i, 3'b000} +: 8];
            if (idx[2:0] == 3'b111) begin
              crc_acc_next = ors_pkg::crc_fold(crc_acc, byte_new);
            end
            if (bit_pos == PosW'(RomBits)) begin
              pass_active_next = 1'b0;
              if (crc_acc_next != 8'd0) begin
                last_disc_next   = '0;
                last_dev_next    = 1'b0;
                family_disc_next = '0;
                status           = ors_pkg::ST_CRC_ERROR;
              end else if (rom_code_next[7:0] == 8'd0) begin
                last_disc_next   = '0;
                last_dev_next    = 1'b0;
                family_disc_next = '0;
                status           = ors_pkg::ST_NO_RESPONSE;
              end else begin
                last_disc_next = zero_fork_next;
                if (zero_fork_next == '0) begin
                  last_dev_next = 1'b1;
                end
                status = ors_pkg::ST_FOUND;
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res.status             = status;
    res.dir_valid          = dvalid;
    res.write_dir          = dir;
    res.rom_id             = RomIdW'(rom_code_next);
    res.last_device        = last_dev_next;
    res.family_discrepancy = family_disc_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_disc   <= '0;
      last_dev    <= 1'b0;
      family_disc <= '0;
      rom_code    <= '0;
      bit_pos     <= PosW'(1);
      zero_fork   <= '0;
      crc_acc     <= '0;
      pass_active <= 1'b0;
    end else if (en) begin
      last_disc   <= last_disc_next;
      last_dev    <= last_dev_next;
      family_disc <= family_disc_next;
      rom_code    <= rom_code_next;
      bit_pos     <= bit_pos_next;
      zero_fork   <= zero_fork_next;
      crc_acc     <= crc_acc_next;
      pass_active <= pass_active_next;
    end
  end

endmodule

// ===== src/onewire_rom_search_engine.sv =====
// ----------------------------------------------------------------------------
// onewire_rom_search_engine: decision engine of the 1-Wire ROM search
// Input register, combinational decision logic and a result register.
// ----------------------------------------------------------------------------
// usage
//   s_* carries requests: tuser selects begin first, begin next or bit pair,
//   tdata holds the presence flag and the id / complement bits of a slot pair.
//   m_* returns one result per request: the status code in tuser, and in
//   tdata the direction bit to write, the rom code and discrepancy info.
//   a request in the input register moves into the result register at an edge
//   where that register is empty or being emptied; m_tvalid rises with it.
//   one request per cycle is sustained while m_tready stays high; the decision
//   logic between the input register and the result register is combinational,
//   so back-to-back bit pairs need no gaps.
//   when m_tready is low the result register holds, the input register
//   keeps one more request, then s_tready drops until the result is taken.
//   rst (synchronous) empties both registers and restores the search state:
//   no pass open, discrepancies and rom code zero, bit position one.
// ----------------------------------------------------------------------------
module onewire_rom_search_engine #(
  parameter int ROM_BYTES = ors_pkg::ROM_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // presence, id_bit, cmp_bit, zero fill
  input  logic [1:0]  s_tuser,   // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // dir_valid, write_dir, rom_id[63:0],
                                 // last_device, family_discrepancy[3:0], zero fill
  output logic [2:0]  m_tuser    // status
);

  ors_pkg::req_t s_req;
  ors_pkg::req_t req;
  ors_pkg::res_t res;
  ors_pkg::res_t out_res;
  logic          req_valid;
  logic          advance;

  assign s_req.func     = s_tuser;
  assign s_req.presence = s_tdata[0];
  assign s_req.id_bit   = s_tdata[1];
  assign s_req.cmp_bit  = s_tdata[2];

  // move on when the result register is empty or being emptied
  assign advance = req_valid && (!m_tvalid || m_tready);

  ors_in_stage u_in_stage (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_tvalid),
    .s_ready (s_tready),
    .s_req   (s_req),
    .take    (advance),
    .valid   (req_valid),
    .req     (req)
  );

  ors_core #(
    .ROM_BYTES (ROM_BYTES)
  ) u_core (
    .clk (clk),
    .rst (rst),
    .en  (advance),
    .req (req),
    .res (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_tuser = out_res.status;
  assign m_tdata = {1'b0, out_res.family_discrepancy, out_res.last_device,
                    out_res.rom_id, out_res.write_dir, out_res.dir_valid};

endmodule

// ===== sim/search_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// search_checker: result checker for the rom search engine
// Watches both stream ports, keeps its own copy of the search state, works
// out the result due for every accepted request and compares each returned
// result with the oldest one due.
// ----------------------------------------------------------------------------
module search_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [71:0] m_tdata,
  input  logic [2:0]  m_tuser,
  output int          mismatches,
  output int          outstanding
);

  typedef struct packed {
    ors_pkg::status_t status;
    logic             dir_valid;
    logic             write_dir;
    logic [63:0]      rom_id;
    logic             last_device;
    logic [3:0]       family_disc;
  } search_res_t;

  search_res_t pending_results[$];

  logic [6:0]  last_disc  = '0;
  logic        last_dev   = 1'b0;
  logic [3:0]  fam_disc   = '0;
  logic [63:0] rom        = '0;
  logic [6:0]  bit_pos    = 7'd1;
  logic [6:0]  zero_pos   = '0;
  logic [7:0]  crc        = '0;
  logic        pass_on    = 1'b0;
  int          fail_cnt   = 0;

  // serial form of the reflected crc-8, lsb of the byte first
  function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] data);
    logic [7:0] c;
    logic       fb;
    c = acc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ data[i];
      c  = c >> 1;
      if (fb) begin
        c = c ^ 8'h8C;
      end
    end
    return c;
  endfunction

  function automatic void drop_search();
    last_disc = '0;
    last_dev  = 1'b0;
    fam_disc  = '0;
  endfunction

  function automatic search_res_t step_search(input logic [1:0] fn, input logic pres,
                                              input logic idb, input logic cmpb);
    search_res_t r;
    logic [6:0]  idx;
    logic        dir;
    r = '0;
    r.status = ors_pkg::ST_IGNORED;
    case (fn)
      ors_pkg::FUNC_FIRST, ors_pkg::FUNC_NEXT: begin
        if (fn == ors_pkg::FUNC_FIRST) begin
          drop_search();
        end
        bit_pos  = 7'd1;
        zero_pos = '0;
        crc      = '0;
        pass_on  = 1'b0;
        if (last_dev) begin
          drop_search();
          r.status = ors_pkg::ST_EXHAUSTED;
        end else if (!pres) begin
          drop_search();
          r.status = ors_pkg::ST_NO_PRESENCE;
        end else begin
          pass_on  = 1'b1;
          r.status = ors_pkg::ST_STARTED;
        end
      end
      ors_pkg::FUNC_BIT: begin
        if (pass_on && idb && cmpb) begin
          pass_on = 1'b0;
          drop_search();
          r.status = ors_pkg::ST_NO_RESPONSE;
        end else if (pass_on) begin
          idx = bit_pos - 7'd1;
          if (idb != cmpb) begin
            dir = idb;
          end else begin
            // both devices answer: follow the earlier path, branch at the last fork
            if (bit_pos < last_disc) begin
              dir = rom[idx[5:0]];
            end else begin
              dir = (bit_pos == last_disc);
            end
            if (!dir) begin
              zero_pos = bit_pos;
              if (zero_pos < ors_pkg::FAMILY_LIMIT) begin
                fam_disc = zero_pos[3:0];
              end
            end
          end
          rom[idx[5:0]] = dir;
          r.dir_valid = 1'b1;
          r.write_dir = dir;
          bit_pos = bit_pos + 7'd1;
          r.status = ors_pkg::ST_RUNNING;
          if (idx[2:0] == 3'd7) begin
            crc = crc8_step(crc, rom[{idx[5:3], 3'b000} +: 8]);
          end
          if (bit_pos > 7'd64) begin
            pass_on = 1'b0;
            if (crc != 8'd0) begin
              drop_search();
              r.status = ors_pkg::ST_CRC_ERROR;
            end else if (rom[7:0] == 8'd0) begin
              drop_search();
              r.status = ors_pkg::ST_NO_RESPONSE;
            end else begin
              last_disc = zero_pos;
              if (last_disc == 7'd0) begin
                last_dev = 1'b1;
              end
              r.status = ors_pkg::ST_FOUND;
            end
          end
        end
      end
      default: ;
    endcase
    r.rom_id      = rom;
    r.last_device = last_dev;
    r.family_disc = fam_disc;
    return r;
  endfunction

  task automatic check_field(input string what, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin
    search_res_t want;
    if (rst) begin
      drop_search();
      rom      = '0;
      bit_pos  = 7'd1;
      zero_pos = '0;
      crc      = '0;
      pass_on  = 1'b0;
      pending_results.delete();
    end else begin
      // a result leaves only after its request has passed both registers, so pop before push
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with nothing expected, status %0d", $time, m_tuser);
          fail_cnt++;
        end else begin
          want = pending_results.pop_front();
          check_field("status", 64'(want.status), 64'(m_tuser));
          check_field("dir_valid", 64'(want.dir_valid), 64'(m_tdata[0]));
          check_field("write_dir", 64'(want.write_dir), 64'(m_tdata[1]));
          check_field("rom_id", want.rom_id, m_tdata[65:2]);
          check_field("last_device", 64'(want.last_device), 64'(m_tdata[66]));
          check_field("family_discrepancy", 64'(want.family_disc), 64'(m_tdata[70:67]));
        end
      end
      if (s_tvalid && s_tready) begin
        pending_results.push_back(step_search(s_tuser, s_tdata[0], s_tdata[1], s_tdata[2]));
      end
    end
    mismatches  <= fail_cnt;
    outstanding <= pending_results.size();
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench top of the rom search engine
// Drives search requests from a few device buses built with valid crc codes,
// closed-loop walks that answer each slot from the direction just written,
// replayed single-device passes, corrupted and random slot streams and
// junk requests, under random bursts and result stalls.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [1:0] FUNC_RSVD      = 2'd3;
  localparam int         RANDOM_ITEMS   = 1450;
  localparam int         TIMEOUT_CYCLES = 400000;
  localparam int         MAX_DEVICES    = 6;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = '0;   // presence, id_bit, cmp_bit, zero fill
  logic [1:0]  s_tuser  = '0;   // func
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;         // dir_valid, write_dir, rom_id[63:0],
                                // last_device, family_discrepancy[3:0], zero fill
  logic [2:0]  m_tuser;         // status

  int          mismatches;
  int          outstanding;

  int          sent_cnt   = 0;
  int          noise_sent = 0;
  int          burst_left = 0;
  int          taken_cnt  = 0;
  logic        last_dir   = 1'b0;
  logic [2:0]  last_status = '0;
  int          cycle_cnt  = 0;
  int          rx_mode    = 0;
  int          rx_left    = 0;

  logic [63:0] bus_dev [0:MAX_DEVICES-1];
  int          bus_count = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  onewire_rom_search_engine DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  search_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // result side: phases of free flow, light stalls and heavy back-pressure
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 2);
      rx_left <= $urandom_range(40, 300);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      default: m_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // the bus model needs the direction actually written
  always @(posedge clk) begin
    if (m_tvalid && m_tready) begin
      taken_cnt   <= taken_cnt + 1;
      last_dir    <= m_tdata[1];
      last_status <= m_tuser;
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= TIMEOUT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // crc byte over family and serial number, bits in bus order
  function automatic logic [7:0] rom_crc(input logic [55:0] body);
    logic [7:0] c;
    logic       fb;
    c = '0;
    for (int i = 0; i < 56; i++) begin
      fb = c[0] ^ body[i];
      c  = c >> 1;
      if (fb) begin
        c = c ^ 8'h8C;
      end
    end
    return c;
  endfunction

  function automatic logic [63:0] make_rom(input logic [7:0] family);
    logic [31:0] hi;
    logic [15:0] lo;
    logic [55:0] body;
    hi   = $urandom();
    lo   = 16'($urandom());
    body = {hi, lo, family};
    return {rom_crc(body), body};
  endfunction

  function automatic logic [7:0] pick_family();
    if ($urandom_range(0, 19) == 0) begin
      return 8'h00;
    end
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic send_req(input logic [1:0] fn, input logic pres, input logic idb,
                          input logic cmpb);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 48);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= fn;
    s_tdata  <= {5'b0, cmpb, idb, pres};
    do @(posedge clk); while (!s_tready);
    sent_cnt++;
  endtask

  task automatic wait_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (taken_cnt != sent_cnt);
  endtask

  task automatic build_bus();
    bus_count = $urandom_range(1, MAX_DEVICES - 1);
    for (int i = 0; i < bus_count; i++) begin
      // shared families push the forks past the family byte
      if (i > 0 && $urandom_range(0, 2) == 0) begin
        bus_dev[i] = make_rom(bus_dev[0][7:0]);
      end else begin
        bus_dev[i] = make_rom(pick_family());
      end
    end
  endtask

  // full enumeration, each slot answered by wired-and of the devices still in
  task automatic walk_bus();
    bit   alive [0:MAX_DEVICES-1];
    int   pass;
    int   b;
    bit   done;
    bit   running;
    logic idb;
    logic cmpb;
    done = 0;
    pass = 0;
    while (!done && pass < bus_count + 2) begin
      send_req(pass == 0 ? ors_pkg::FUNC_FIRST : ors_pkg::FUNC_NEXT,
               $urandom_range(0, 19) != 0,
               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      wait_results();
      if (last_status != ors_pkg::ST_STARTED) begin
        done = 1;
      end else begin
        for (int i = 0; i < MAX_DEVICES; i++) begin
          alive[i] = (i < bus_count);
        end
        running = 1;
        b = 0;
        while (running && b < 64) begin
          idb  = 1'b1;
          cmpb = 1'b1;
          for (int i = 0; i < bus_count; i++) begin
            if (alive[i]) begin
              idb  = idb & bus_dev[i][b];
              cmpb = cmpb & ~bus_dev[i][b];
            end
          end
          if ($urandom_range(0, 399) == 0) begin
            {idb, cmpb} = 2'b11;
          end
          send_req(ors_pkg::FUNC_BIT, 1'($urandom_range(0, 1)), idb, cmpb);
          wait_results();
          if (last_status != ors_pkg::ST_RUNNING) begin
            running = 0;
          end
          for (int i = 0; i < bus_count; i++) begin
            if (bus_dev[i][b] != last_dir) begin
              alive[i] = 0;
            end
          end
          b++;
        end
        if (last_status != ors_pkg::ST_FOUND) begin
          done = 1;
        end
      end
      pass++;
    end
  endtask

  // one device replayed without waiting; optional flipped bit or forced forks
  task automatic replay_rom(input logic [63:0] rom, input int flip, input bit forks);
    logic idb;
    send_req((forks || $urandom_range(0, 4) != 0) ? ors_pkg::FUNC_FIRST : ors_pkg::FUNC_NEXT,
             1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    for (int b = 0; b < 64; b++) begin
      // a zero bit may be shared with an unseen device: the first pass takes zero
      if (forks && !rom[b] && $urandom_range(0, 5) == 0) begin
        send_req(ors_pkg::FUNC_BIT, 1'($urandom_range(0, 1)), 1'b0, 1'b0);
      end else begin
        idb = rom[b] ^ (b == flip);
        send_req(ors_pkg::FUNC_BIT, 1'($urandom_range(0, 1)), idb, ~idb);
      end
    end
    if ($urandom_range(0, 1) == 0) begin
      send_req(ors_pkg::FUNC_NEXT, 1'b1, 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)));
    end
  endtask

  task automatic scribble(input int len);
    int r;
    send_req(2'($urandom_range(0, 1)), $urandom_range(0, 7) != 0,
             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 15);
      if (r == 0) begin
        send_req(ors_pkg::FUNC_BIT, 1'($urandom_range(0, 1)), 1'b1, 1'b1);
      end else if (r < 5) begin
        send_req(ors_pkg::FUNC_BIT, 1'($urandom_range(0, 1)), 1'b0, 1'b0);
      end else if (r == 5) begin
        send_req(ors_pkg::FUNC_NEXT, 1'b1, 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
      end else begin
        r = $urandom_range(0, 1);
        send_req(ors_pkg::FUNC_BIT, 1'($urandom_range(0, 1)), r[0], ~r[0]);
      end
    end
  endtask

  task automatic noise(input int n);
    for (int i = 0; i < n; i++) begin
      send_req(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
    noise_sent += n;
  endtask

  initial begin
    int pick;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // short directed opening
    send_req(ors_pkg::FUNC_BIT, 1'b0, 1'b1, 1'b0);     // no pass open
    send_req(FUNC_RSVD, 1'b1, 1'b1, 1'b1);
    send_req(ors_pkg::FUNC_NEXT, 1'b0, 1'b0, 1'b0);    // no presence
    send_req(ors_pkg::FUNC_FIRST, 1'b1, 1'b0, 1'b0);
    send_req(ors_pkg::FUNC_BIT, 1'b0, 1'b1, 1'b1);     // nobody answers
    send_req(ors_pkg::FUNC_BIT, 1'b1, 1'b0, 1'b1);
    send_req(ors_pkg::FUNC_FIRST, 1'b1, 1'b1, 1'b1);
    send_req(ors_pkg::FUNC_BIT, 1'b0, 1'b0, 1'b0);
    send_req(ors_pkg::FUNC_BIT, 1'b1, 1'b1, 1'b0);
    send_req(ors_pkg::FUNC_BIT, 1'b0, 1'b0, 1'b1);
    send_req(FUNC_RSVD, 1'b0, 1'b0, 1'b0);
    send_req(ors_pkg::FUNC_NEXT, 1'b1, 1'b0, 1'b0);    // abandons the pass
    send_req(ors_pkg::FUNC_FIRST, 1'b0, 1'b1, 1'b1);

    // all-zero code, a lone device then exhausted, and a crc error
    replay_rom(64'h0, -1, 1'b0);
    replay_rom(make_rom(8'hFF), -1, 1'b0);
    send_req(ors_pkg::FUNC_NEXT, 1'b1, 1'b1, 1'b1);
    replay_rom(make_rom(8'h01), $urandom_range(0, 63), 1'b0);

    while (sent_cnt - noise_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        build_bus();
        walk_bus();
      end else if (pick < 65) begin
        replay_rom(make_rom(pick_family()),
                   ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : -1,
                   1'($urandom_range(0, 1)));
      end else if (pick < 80) begin
        scribble($urandom_range(1, 70));
      end else begin
        noise($urandom_range(1, 8));
      end
    end

    wait_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== onewire_rom_search_engine.f =====
src/ors_pkg.sv
src/ors_in_stage.sv
src/ors_core.sv
src/onewire_rom_search_engine.sv
sim/search_checker.sv
sim/tb.sv
